[hdl/patk_pkg.sv]
package patk_pkg;
	localparam int NUM_VARS_DEF    = 1024;
	localparam int MAX_SVARS_DEF   = 1024;
	localparam int MAX_PICK_DEF    = 16;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int VAR_W   = 10;
	localparam int SCORE_W = 32;
	localparam int PICK_W  = 5;

	typedef enum logic [1:0] {
		OP_RECORD = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INC_RD,
		ST_INC_WR,
		ST_CLR,
		ST_Q_LIST,
		ST_Q_CNT,
		ST_Q_MUL,
		ST_Q_SCAN,
		ST_Q_SHIFT,
		ST_EMIT
	} state_t;
endpackage

[hdl/patk_if.sv]
interface patk_in_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 operation;
	logic [patk_pkg::VAR_W-1:0] variable;
	logic                       polarity;
	logic [patk_pkg::PICK_W-1:0] pick_count;
	modport source (output valid, operation, variable, polarity, pick_count, input ready);
	modport sink (input valid, operation, variable, polarity, pick_count, output ready);
endinterface

interface patk_out_if;
	logic                         valid;
	logic                         ready;
	logic [patk_pkg::VAR_W-1:0]   picked_variable;
	logic [patk_pkg::SCORE_W-1:0] score;
	logic                         last;
	modport source (output valid, picked_variable, score, last, input ready);
	modport sink (input valid, picked_variable, score, last, output ready);
endinterface

[hdl/polarity_activity_top_k_unit.sv]
// Polarity activity top-k unit. A record steps through a counter read, a write and a return to
// idle; an append completes in idle; a clear zeroes one counter pair per cycle (block
// not ready meanwhile; the same clearing pass runs once after reset). A query with list
// length L and k = min(pick_count, MAX_PICK, L) walks all L entries, then makes k output
// transfers: each listed entry costs a list read, a counter read, one shared multiply, and a
// one-slot-per-cycle scan and shift of the pick buffer. Counters live in single-port memories.
module polarity_activity_top_k_unit #(
	parameter int NUM_VARS    = patk_pkg::NUM_VARS_DEF,
	parameter int MAX_SVARS   = patk_pkg::MAX_SVARS_DEF,
	parameter int MAX_PICK    = patk_pkg::MAX_PICK_DEF,
	parameter int COUNT_WIDTH = patk_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	patk_in_if.sink    in_ch,
	patk_out_if.source out_ch
);
	import patk_pkg::*;
	localparam int AW  = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
	localparam int LW  = (MAX_SVARS > 1) ? $clog2(MAX_SVARS) : 1;
	localparam int LCW = $clog2(MAX_SVARS + 1);
	localparam int PW  = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
	localparam int PCW = $clog2(MAX_PICK + 1);
	localparam int PRW = 2 * COUNT_WIDTH;
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	logic [COUNT_WIDTH-1:0] neg_mem [NUM_VARS];
	logic [COUNT_WIDTH-1:0] pos_mem [NUM_VARS];
	logic [VAR_W-1:0]       list_mem [MAX_SVARS];
	logic [VAR_W-1:0]       bvar_q [MAX_PICK];
	logic [PRW-1:0]         bprod_q [MAX_PICK];

	state_t state_q, state_d;
	logic [AW-1:0]  addr_q;
	logic [AW-1:0]  rd_addr;
	logic           pol_q;
	logic [LCW-1:0] cnt_q, idx_q;
	logic [PCW-1:0] n_q, len_q, pos_q, sh_q, emit_q;
	logic [VAR_W-1:0] v_q;
	logic [COUNT_WIDTH-1:0] nrd_q, prd_q;
	logic [PRW-1:0] prod_q;
	logic [VAR_W-1:0] lrd_q;

	logic acc, vok;
	logic [PCW-1:0] want_c;
	assign acc = in_ch.valid && in_ch.ready;
	assign vok = (in_ch.variable != '0) && ({22'd0, in_ch.variable} <= 32'(NUM_VARS));
	// listed variables are always in range, so the counter address is the list entry less one
	assign rd_addr = (state_q == ST_Q_CNT) ? AW'(lrd_q - 1'b1) : addr_q;
	always_comb begin
		want_c = (32'(in_ch.pick_count) > 32'(MAX_PICK)) ? PCW'(MAX_PICK)
			: PCW'(in_ch.pick_count);
		if (32'(want_c) > 32'(cnt_q)) want_c = PCW'(cnt_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (acc) begin
				unique case (op_t'(in_ch.operation))
					OP_RECORD: state_d = vok ? ST_INC_RD : ST_IDLE;
					OP_APPEND: state_d = ST_IDLE;
					OP_QUERY:  state_d = (want_c == '0) ? ST_IDLE : ST_Q_LIST;
					OP_CLEAR:  state_d = ST_CLR;
				endcase
			end
			ST_INC_RD:  state_d = ST_INC_WR;
			ST_INC_WR:  state_d = ST_IDLE;
			ST_CLR:     if (32'(addr_q) == NUM_VARS - 1) state_d = ST_IDLE;
			ST_Q_LIST:  state_d = ST_Q_CNT;
			ST_Q_CNT:   state_d = ST_Q_MUL;
			ST_Q_MUL:   state_d = ST_Q_SCAN;
			ST_Q_SCAN:  if (pos_q >= len_q || bprod_q[pos_q[PW-1:0]] < prod_q)
				state_d = ST_Q_SHIFT;
			ST_Q_SHIFT: if (sh_q <= pos_q)
				state_d = (32'(idx_q) + 1 >= 32'(cnt_q)) ? ST_EMIT : ST_Q_LIST;
			ST_EMIT:    if (out_ch.ready && 32'(emit_q) + 1 == 32'(len_q)) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ch.ready = (state_q == ST_IDLE);
		out_ch.valid = (state_q == ST_EMIT);
		out_ch.picked_variable = bvar_q[emit_q[PW-1:0]];
		out_ch.score = (PRW > SCORE_W && (bprod_q[emit_q[PW-1:0]] >> SCORE_W) != '0)
			? '1 : SCORE_W'(bprod_q[emit_q[PW-1:0]]);
		out_ch.last = (32'(emit_q) + 1 == 32'(len_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			addr_q <= '0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) addr_q <= addr_q + 1'b1;
			if (state_q == ST_IDLE && acc) begin
				unique case (op_t'(in_ch.operation))
					OP_RECORD: addr_q <= AW'(in_ch.variable - 1'b1);
					OP_APPEND: if (vok && 32'(cnt_q) < MAX_SVARS) cnt_q <= cnt_q + 1'b1;
					OP_QUERY:  ;
					OP_CLEAR:  begin addr_q <= '0; cnt_q <= '0; end
				endcase
			end
		end
	end

	// counter and list memories
	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) begin
			neg_mem[addr_q] <= '0;
			pos_mem[addr_q] <= '0;
		end else if (state_q == ST_INC_WR) begin
			if (pol_q) begin
				if (prd_q != CMAX) pos_mem[addr_q] <= prd_q + 1'b1;
			end else if (nrd_q != CMAX) neg_mem[addr_q] <= nrd_q + 1'b1;
		end
		if (state_q == ST_INC_RD || state_q == ST_Q_CNT) begin
			nrd_q <= neg_mem[rd_addr];
			prd_q <= pos_mem[rd_addr];
		end
		if (state_q == ST_IDLE && acc && op_t'(in_ch.operation) == OP_APPEND && vok &&
		    32'(cnt_q) < MAX_SVARS)
			list_mem[cnt_q[LW-1:0]] <= in_ch.variable;
		if (state_q == ST_Q_LIST) lrd_q <= list_mem[idx_q[LW-1:0]];
	end

	// query sequencer datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				pol_q <= in_ch.polarity;
				n_q <= want_c;
				len_q <= '0;
				idx_q <= '0;
				emit_q <= '0;
			end
			ST_Q_LIST: ;
			ST_Q_CNT: v_q <= lrd_q;
			ST_Q_MUL: begin
				prod_q <= PRW'(nrd_q) * PRW'(prd_q);
				pos_q <= '0;
			end
			ST_Q_SCAN: begin
				if (state_d == ST_Q_SHIFT)
					sh_q <= (len_q < n_q) ? len_q : n_q - 1'b1;
				else pos_q <= pos_q + 1'b1;
			end
			ST_Q_SHIFT: begin
				// shift one slot down per cycle, then drop the new entry in
				if (pos_q < n_q) begin
					if (sh_q > pos_q) begin
						bvar_q[sh_q[PW-1:0]] <= bvar_q[sh_q[PW-1:0] - 1'b1];
						bprod_q[sh_q[PW-1:0]] <= bprod_q[sh_q[PW-1:0] - 1'b1];
						sh_q <= sh_q - 1'b1;
					end else begin
						bvar_q[pos_q[PW-1:0]] <= v_q;
						bprod_q[pos_q[PW-1:0]] <= prod_q;
						if (len_q < n_q) len_q <= len_q + 1'b1;
					end
				end
				if (sh_q <= pos_q) idx_q <= idx_q + 1'b1;
			end
			ST_EMIT: if (out_ch.ready) emit_q <= emit_q + 1'b1;
			default: ;
		endcase
	end
endmodule

[hdl/patk_checker.sv]
module patk_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_last
);
	a_excl: assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("ready while emitting");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid) else $error("extra result");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid) else $error("query cut short");
endmodule

bind polarity_activity_top_k_unit patk_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last));
